### design/cold_region_pruner_assert.svh
// Assertion macros shared by the checker of the cold region pruner.
`ifndef COLD_REGION_PRUNER_ASSERT_SVH
`define COLD_REGION_PRUNER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cold_region_pruner check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cold_region_pruner check failed");

`endif

### design/crp_pkg.sv
// Package of the cold region pruner: sizes, codes and word types.
package crp_pkg;

   localparam int TABLE_DEPTH     = 32;
   localparam int KEY_WIDTH       = 32;
   localparam int STREAK_WIDTH    = 16;
   localparam int UTIL_WIDTH      = 17;
   localparam int SLOT_WIDTH      = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH     = $clog2(TABLE_DEPTH + 1);
   localparam int CSR_WIDTH       = UTIL_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int FQ_DEPTH        = 2;
   localparam int RSP_DEPTH       = 4;

   typedef logic [KEY_WIDTH-1:0]    key_type;
   typedef logic [STREAK_WIDTH-1:0] streak_type;
   typedef logic [SLOT_WIDTH-1:0]   slot_type;
   typedef logic [COUNT_WIDTH-1:0]  count_type;
   typedef logic [UTIL_WIDTH-1:0]   util_type;

   localparam util_type   COLD_BELOW_RESET   = util_type'(655);
   localparam streak_type PRUNE_STREAK_RESET = streak_type'(10);
   localparam count_type  KEEP_REGIONS_RESET = count_type'(1);
   localparam streak_type STREAK_MAX         = '1;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_COLD_BELOW   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRUNE_STREAK = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEEP_REGIONS = 2'd2;

   typedef enum logic {
      OP_FEED  = 1'b0,
      OP_SWEEP = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ACCEPTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_PRUNED   = 2'd2,
      ST_NONE     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ENG_LOOK,
      ENG_FEED,
      ENG_SWEEP,
      ENG_END
   } eng_state_type;

   typedef struct packed {
      op_type     op;
      key_type    region_key;
      util_type   utilization;
      logic       end_of_pass;
   } req_type;

   typedef struct packed {
      status_type status;
      slot_type   slot;
      key_type    out_key;
      streak_type streak;
      count_type  pruned_count;
      logic       last;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      key_type    key;
      logic       cold;
   } work_type;

endpackage

### design/crp_front.sv
// Front part: accepts request words, classifies them and queues them for the engine.
module crp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  crp_pkg::req_type   req_data,
   input  crp_pkg::util_type  cold_below,
   output logic               work_valid,
   output crp_pkg::work_type  work_data,
   input  logic               work_pop
);
   import crp_pkg::*;

   localparam int PTR_WIDTH = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(FQ_DEPTH + 1);

   work_type               queue_ff [FQ_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   push_ok, pop_ok;
   work_type               entry;

   assign req_full   = (count_ff == CNT_WIDTH'(FQ_DEPTH));
   assign work_valid = (count_ff != '0);
   assign work_data  = queue_ff[rd_ptr_ff];
   assign push_ok    = req_push && !req_full;
   assign pop_ok     = work_pop && work_valid;

   always_comb begin
      entry.op   = req_data.op;
      entry.key  = req_data.region_key;
      entry.cold = (req_data.utilization < cold_below);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(FQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(FQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

endmodule

### design/crp_engine.sv
// Back part: holds the region table and carries out feed and sweep words.
module crp_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                work_valid,
   input  crp_pkg::work_type   work_data,
   output logic                work_pop,
   input  crp_pkg::streak_type prune_streak,
   input  crp_pkg::count_type  keep_regions,
   input  logic                out_full,
   output logic                out_push,
   output crp_pkg::rsp_type    out_word
);
   import crp_pkg::*;

   function automatic slot_type lowest_slot(input logic [TABLE_DEPTH-1:0] vec);
      slot_type idx;
      idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (vec[i]) begin
            idx = slot_type'(i);
         end
      end
      return idx;
   endfunction

   key_type                 key_ff    [TABLE_DEPTH];
   streak_type              streak_ff [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   count_type               active_ff, active_in;
   eng_state_type           state_ff, state_in;
   work_type                cur_ff, cur_in;
   slot_type                slot_ff, slot_in;
   logic                    hit_ff, hit_in;
   logic                    room_ff, room_in;
   count_type               pruned_ff, pruned_in;
   rsp_type                 pend_ff, pend_in;
   logic                    pend_valid_ff, pend_valid_in;

   logic [TABLE_DEPTH-1:0]  match;
   streak_type              streak_rd;
   streak_type              streak_in;
   logic                    streak_we, key_we;
   logic                    cand;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == work_data.key);
      end
   end

   assign streak_rd = streak_ff[slot_ff];
   assign cand      = valid_ff[slot_ff] && (streak_rd >= prune_streak);

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      slot_in       = slot_ff;
      hit_in        = hit_ff;
      room_in       = room_ff;
      pruned_in     = pruned_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      valid_in      = valid_ff;
      active_in     = active_ff;
      work_pop      = 1'b0;
      out_push      = 1'b0;
      out_word      = '0;
      streak_in     = '0;
      streak_we     = 1'b0;
      key_we        = 1'b0;
      case (state_ff)
         ENG_LOOK: begin
            if (work_valid) begin
               work_pop = 1'b1;
               cur_in   = work_data;
               if (work_data.op == OP_FEED) begin
                  hit_in   = |match;
                  room_in  = ~&valid_ff;
                  slot_in  = (|match) ? lowest_slot(match) : lowest_slot(~valid_ff);
                  state_in = ENG_FEED;
               end else begin
                  slot_in       = '0;
                  pruned_in     = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ENG_SWEEP;
               end
            end
         end
         ENG_FEED: begin
            if (!out_full) begin
               out_push         = 1'b1;
               state_in         = ENG_LOOK;
               out_word.out_key = cur_ff.key;
               out_word.last    = 1'b1;
               if (!hit_ff && !room_ff) begin
                  out_word.status = ST_DROPPED;
               end else begin
                  if (!cur_ff.cold) begin
                     streak_in = '0;
                  end else if (hit_ff && (streak_rd == STREAK_MAX)) begin
                     streak_in = streak_rd;
                  end else if (hit_ff) begin
                     streak_in = streak_rd + 1'b1;
                  end else begin
                     streak_in = streak_type'(1);
                  end
                  streak_we       = 1'b1;
                  out_word.status = ST_ACCEPTED;
                  out_word.slot   = slot_ff;
                  out_word.streak = streak_in;
                  if (!hit_ff) begin
                     key_we            = 1'b1;
                     valid_in[slot_ff] = 1'b1;
                     active_in         = active_ff + 1'b1;
                  end
               end
            end
         end
         ENG_SWEEP: begin
            if (cand && (active_ff <= keep_regions)) begin
               state_in = ENG_END;
            end else if (!(cand && pend_valid_ff && out_full)) begin
               if (cand) begin
                  if (pend_valid_ff) begin
                     out_push = 1'b1;
                     out_word = pend_ff;
                  end
                  pend_in.status       = ST_PRUNED;
                  pend_in.slot         = slot_ff;
                  pend_in.out_key      = key_ff[slot_ff];
                  pend_in.streak       = streak_rd;
                  pend_in.pruned_count = pruned_ff + 1'b1;
                  pend_in.last         = 1'b0;
                  pend_valid_in        = 1'b1;
                  pruned_in            = pruned_ff + 1'b1;
                  valid_in[slot_ff]    = 1'b0;
                  active_in            = active_ff - 1'b1;
               end
               if (slot_ff == slot_type'(TABLE_DEPTH - 1)) begin
                  state_in = ENG_END;
               end else begin
                  slot_in = slot_ff + 1'b1;
               end
            end
         end
         ENG_END: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = ENG_LOOK;
               if (pend_valid_ff) begin
                  out_word      = pend_ff;
                  out_word.last = 1'b1;
               end else begin
                  out_word.status = ST_NONE;
                  out_word.last   = 1'b1;
               end
            end
         end
         default: begin
            state_in = ENG_LOOK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ENG_LOOK;
         valid_ff      <= '0;
         active_ff     <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         active_ff     <= active_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      slot_ff   <= slot_in;
      hit_ff    <= hit_in;
      room_ff   <= room_in;
      pruned_ff <= pruned_in;
      pend_ff   <= pend_in;
      if (streak_we) begin
         streak_ff[slot_ff] <= streak_in;
      end
      if (key_we) begin
         key_ff[slot_ff] <= cur_ff.key;
      end
   end

endmodule

### design/crp_rsp_fifo.sv
// Result queue between the engine and the response channel.
module crp_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  crp_pkg::rsp_type in_word,
   output logic             in_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output crp_pkg::rsp_type rsp_data
);
   import crp_pkg::*;

   localparam int PTR_WIDTH = (RSP_DEPTH > 1) ? $clog2(RSP_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(RSP_DEPTH + 1);

   rsp_type                queue_ff [RSP_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   push_ok, pop_ok;

   assign in_full   = (count_ff == CNT_WIDTH'(RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign push_ok   = in_push && !in_full;
   assign pop_ok    = rsp_pop && !rsp_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

### design/cold_region_pruner.sv
// Top level of the cold region pruner: configuration registers and the three parts.
//
// Request words enter through req_push / req_full; each is a feed sample (op low)
// or a sweep (op high). Result words leave through rsp_empty / rsp_pop, oldest
// first. The configuration registers are written through csr_we, csr_index and
// csr_wdata.
// A feed gives one result word. It passes the request queue, the look state (key
// compare), the feed state (table update) and the result queue, one feed at a time.
// A sweep walks the 32 table slots, one slot per cycle unless a pruned word
// waits on a full result queue, stopping at a candidate once at most keep_regions
// regions are live; it gives one word per pruned region or one "pruned none" word.
// Reset empties the table and both queues and loads the default configuration.
// When the receiver stalls, a four word result queue fills, the engine waits,
// a two word request queue fills behind it, and then req_full rises.
module cold_region_pruner (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  crp_pkg::req_type                      req_data,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output crp_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [crp_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [crp_pkg::CSR_WIDTH-1:0]         csr_wdata
);
   import crp_pkg::*;

   util_type   cold_below_ff, cold_below_in;
   streak_type prune_streak_ff, prune_streak_in;
   count_type  keep_regions_ff, keep_regions_in;

   logic       work_valid, work_pop;
   work_type   work_data;
   logic       eng_push, eng_full;
   rsp_type    eng_word;

   always_comb begin
      cold_below_in   = cold_below_ff;
      prune_streak_in = prune_streak_ff;
      keep_regions_in = keep_regions_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COLD_BELOW:   cold_below_in   = csr_wdata[UTIL_WIDTH-1:0];
            CSR_PRUNE_STREAK: prune_streak_in = csr_wdata[STREAK_WIDTH-1:0];
            CSR_KEEP_REGIONS: keep_regions_in = csr_wdata[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cold_below_ff   <= COLD_BELOW_RESET;
         prune_streak_ff <= PRUNE_STREAK_RESET;
         keep_regions_ff <= KEEP_REGIONS_RESET;
      end else begin
         cold_below_ff   <= cold_below_in;
         prune_streak_ff <= prune_streak_in;
         keep_regions_ff <= keep_regions_in;
      end
   end

   crp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_data   (req_data),
      .cold_below (cold_below_ff),
      .work_valid (work_valid),
      .work_data  (work_data),
      .work_pop   (work_pop)
   );

   crp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .work_valid   (work_valid),
      .work_data    (work_data),
      .work_pop     (work_pop),
      .prune_streak (prune_streak_ff),
      .keep_regions (keep_regions_ff),
      .out_full     (eng_full),
      .out_push     (eng_push),
      .out_word     (eng_word)
   );

   crp_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_push   (eng_push),
      .in_word   (eng_word),
      .in_full   (eng_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

### design/crp_checker.sv
// Port checker of the cold region pruner and its bind to the top level.
`include "cold_region_pruner_assert.svh"

module crp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_push,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input crp_pkg::rsp_type rsp_data
);
   import crp_pkg::*;

   `CRP_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, rsp_empty && !req_full)

   `CRP_ASSERT_NOW(a_full_after_push, clock, reset, $rose(req_full), $past(req_push))

   `CRP_ASSERT_NEXT(a_stalled_word_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))

   `CRP_ASSERT_NOW(a_sweep_continues, clock, reset, (rsp_pop && !rsp_empty && rsp_data.status == ST_PRUNED && !rsp_data.last) ##1 !rsp_empty, rsp_data.status == ST_PRUNED && rsp_data.pruned_count == $past(rsp_data.pruned_count) + 1'b1)

endmodule

bind cold_region_pruner crp_checker u_crp_checker (.*);

### test/tb_cold_region_pruner.sv
// Testbench of the cold region pruner: every result word is checked against a predicted table.
`timescale 1ns / 100ps

module tb_cold_region_pruner;
   import crp_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 50;
   localparam int POOL_SIZE     = 48;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_push  = 1'b0;
   logic                       req_full;
   req_type                    req_data  = '0;
   logic                       rsp_empty;
   logic                       rsp_pop   = 1'b0;
   rsp_type                    rsp_data;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_WIDTH-1:0]       csr_wdata = '0;

   key_type    region_keys [TABLE_DEPTH];
   logic       region_live [TABLE_DEPTH];
   streak_type region_streak [TABLE_DEPTH];
   int         live_regions;
   util_type   cold_below;
   streak_type prune_streak;
   count_type  keep_regions;
   rsp_type    region_results [$];
   key_type    key_pool [POOL_SIZE];
   int         error_count   = 0;
   int         pop_mode      = 0;
   int         pop_mode_left = 0;

   cold_region_pruner i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("cold_region_pruner verification failed");
      $finish;
   end

   function automatic void track_region_word(input req_type word);
      rsp_type res;
      int      slot_idx;
      int      start_live;
      int      pruned;
      bit      stop;
      res = '0;
      if (word.op == OP_FEED) begin
         slot_idx = -1;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_idx < 0 && region_live[i] && region_keys[i] == word.region_key) slot_idx = i;
         end
         if (slot_idx < 0) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_idx < 0 && !region_live[i]) slot_idx = i;
            end
            if (slot_idx >= 0) begin
               region_keys[slot_idx]   = word.region_key;
               region_live[slot_idx]   = 1'b1;
               region_streak[slot_idx] = '0;
               live_regions++;
            end
         end
         res.out_key = word.region_key;
         res.last    = 1'b1;
         if (slot_idx < 0) begin
            res.status = ST_DROPPED;
         end else begin
            if (word.utilization < cold_below) begin
               if (region_streak[slot_idx] != STREAK_MAX) region_streak[slot_idx]++;
            end else begin
               region_streak[slot_idx] = '0;
            end
            res.status = ST_ACCEPTED;
            res.slot   = slot_type'(slot_idx);
            res.streak = region_streak[slot_idx];
         end
         region_results.push_back(res);
      end else begin
         start_live = live_regions;
         pruned     = 0;
         stop       = 1'b0;
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!stop && region_live[i] && region_streak[i] >= prune_streak) begin
               if (start_live - pruned <= int'(keep_regions)) begin
                  stop = 1'b1;
               end else begin
                  region_live[i] = 1'b0;
                  live_regions--;
                  pruned++;
                  res              = '0;
                  res.status       = ST_PRUNED;
                  res.slot         = slot_type'(i);
                  res.out_key      = region_keys[i];
                  res.streak       = region_streak[i];
                  res.pruned_count = count_type'(pruned);
                  region_results.push_back(res);
               end
            end
         end
         if (pruned == 0) begin
            res        = '0;
            res.status = ST_NONE;
            res.last   = 1'b1;
            region_results.push_back(res);
         end else begin
            region_results[region_results.size() - 1].last = 1'b1;
         end
      end
   endfunction

   function automatic void compare_field(input string name, input logic [KEY_WIDTH-1:0] want,
                                         input logic [KEY_WIDTH-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic void check_region_word(input rsp_type got);
      rsp_type want;
      if (region_results.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual %h", $time, got);
         error_count++;
      end else begin
         want = region_results.pop_front();
         compare_field("status", KEY_WIDTH'(want.status), KEY_WIDTH'(got.status));
         compare_field("slot", KEY_WIDTH'(want.slot), KEY_WIDTH'(got.slot));
         compare_field("out_key", want.out_key, got.out_key);
         compare_field("streak", KEY_WIDTH'(want.streak), KEY_WIDTH'(got.streak));
         compare_field("pruned_count", KEY_WIDTH'(want.pruned_count),
                       KEY_WIDTH'(got.pruned_count));
         compare_field("last", KEY_WIDTH'(want.last), KEY_WIDTH'(got.last));
      end
   endfunction

   // The receiver switches between steady, light, heavy and near-blocking stall modes.
   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) check_region_word(rsp_data);
      if (pop_mode_left == 0) begin
         pop_mode      = $urandom_range(0, 3);
         pop_mode_left = $urandom_range(20, 200);
      end else begin
         pop_mode_left--;
      end
      case (pop_mode)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 3) != 0);
         2: rsp_pop <= ($urandom_range(0, 3) == 0);
         default: rsp_pop <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic send_word(input req_type word);
      req_push <= 1'b1;
      req_data <= word;
      @(posedge clock);
      while (req_full) @(posedge clock);
      track_region_word(word);
   endtask

   task automatic feed(input key_type key, input util_type util, input logic eop);
      req_type word;
      word.op          = OP_FEED;
      word.region_key  = key;
      word.utilization = util;
      word.end_of_pass = eop;
      send_word(word);
   endtask

   task automatic sweep_table();
      req_type word;
      word.op          = OP_SWEEP;
      word.region_key  = key_type'($urandom());
      word.utilization = util_type'($urandom_range(0, 65536));
      word.end_of_pass = 1'($urandom_range(0, 1));
      send_word(word);
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_push <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      while (region_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic load_settings(input util_type thr, input streak_type iters,
                                input count_type minr);
      csr_we    <= 1'b1;
      csr_index <= CSR_COLD_BELOW;
      csr_wdata <= thr;
      @(posedge clock);
      csr_index <= CSR_PRUNE_STREAK;
      csr_wdata <= CSR_WIDTH'(iters);
      @(posedge clock);
      csr_index <= CSR_KEEP_REGIONS;
      csr_wdata <= CSR_WIDTH'(minr);
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_wdata <= CSR_WIDTH'($urandom());
      @(posedge clock);
      csr_we       <= 1'b0;
      cold_below   = thr;
      prune_streak = iters;
      keep_regions = minr;
   endtask

   task automatic test_default_settings();
      sweep_table();
      feed(32'h0000_0000, 17'd0, 1'b1);
      feed(32'hFFFF_FFFF, 17'd654, 1'b0);
      feed(32'hFFFF_FFFF, 17'd655, 1'b1);
      feed(32'h0000_0000, 17'd65536, 1'b0);
      feed(32'h0000_0000, 17'd0, 1'b1);
      sweep_table();
      drain_results();
   endtask

   task automatic test_full_table();
      load_settings(17'd65536, 16'd0, 6'd32);
      for (int i = 0; i < TABLE_DEPTH - 2; i++) feed(32'h5A00_0000 + i, 17'd0, 1'b0);
      feed(32'hDEAD_BEEF, 17'd0, 1'b1);
      feed(32'hFFFF_FFFF, 17'd0, 1'b0);
      feed(32'h0BAD_F00D, 17'd0, 1'b0);
      sweep_table();
      drain_results();
      load_settings(17'd65536, 16'd0, 6'd29);
      sweep_table();
      drain_results();
      load_settings(17'd65536, 16'd0, 6'd0);
      sweep_table();
      feed(32'h1234_5678, 17'd100, 1'b0);
      feed(32'h8765_4321, 17'd65536, 1'b1);
      drain_results();
   endtask

   task automatic test_threshold_extremes();
      load_settings(17'd0, 16'd65535, 6'd1);
      feed(32'hA5A5_5A5A, 17'd0, 1'b0);
      sweep_table();
      drain_results();
      load_settings(17'd65536, 16'd65535, 6'd1);
      feed(32'hA5A5_5A5A, 17'd65535, 1'b1);
      feed(32'hA5A5_5A5A, 17'd65536, 1'b0);
      drain_results();
   endtask

   task automatic test_cold_streaks();
      load_settings(17'd65536, 16'd65535, 6'd0);
      for (int n = 0; n < 20; n++) begin
         feed(32'h0C0F_FEE5, util_type'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
      end
      sweep_table();
      drain_results();
   endtask

   task automatic test_random_traffic();
      util_type   thr;
      streak_type iters;
      count_type  minr;
      int         left;
      int         burst;
      req_type    word;
      for (int k = 0; k < POOL_SIZE; k++) key_pool[k] = key_type'($urandom());
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               thr = 17'd32768; iters = 16'd2; minr = 6'd4;
            end
            1: begin
               thr = 17'd65536; iters = 16'd0; minr = 6'd0;
            end
            2: begin
               thr   = util_type'($urandom_range(1, 65536));
               iters = streak_type'($urandom_range(1, 5));
               minr  = count_type'($urandom_range(0, 32));
            end
            default: begin
               thr = 17'd1; iters = 16'd3; minr = 6'd10;
            end
         endcase
         load_settings(thr, iters, minr);
         left = 52;
         while (left > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
               word.op          = ($urandom_range(0, 99) < 8) ? OP_SWEEP : OP_FEED;
               word.region_key  = ($urandom_range(0, 99) < 85) ?
                                  key_pool[$urandom_range(0, POOL_SIZE - 1)] :
                                  key_type'($urandom());
               word.utilization = ($urandom_range(0, 99) < 60) ?
                                  util_type'($urandom_range(0, thr - 1)) :
                                  util_type'($urandom_range(0, 65536));
               word.end_of_pass = 1'($urandom_range(0, 1));
               send_word(word);
               burst--;
               left--;
            end
            idle_sender($urandom_range(0, 6));
         end
         drain_results();
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         region_keys[i]   = '0;
         region_live[i]   = 1'b0;
         region_streak[i] = '0;
      end
      live_regions = 0;
      cold_below   = COLD_BELOW_RESET;
      prune_streak = PRUNE_STREAK_RESET;
      keep_regions = KEEP_REGIONS_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_settings();
      test_full_table();
      test_threshold_extremes();
      test_cold_streaks();
      test_random_traffic();
      if (error_count == 0) begin
         $display("cold_region_pruner verification clean");
      end else begin
         $display("cold_region_pruner verification failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+design
design/crp_pkg.sv
design/crp_front.sv
design/crp_engine.sv
design/crp_rsp_fifo.sv
design/cold_region_pruner.sv
design/crp_checker.sv
test/tb_cold_region_pruner.sv
